FILE: sv/rfab_pkg.sv
// Shared types and constants for the rectangle fill and alpha blend block.
package rfab_pkg;

  // Default clamp ceiling for the frame size registers
  localparam int MAX_DIM_DEF = 4096;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_END_X    = 3'd2,
    REG_END_Y    = 3'd3,
    REG_FRAME_W  = 3'd4,
    REG_FRAME_H  = 3'd5,
    REG_FILL_CLR = 3'd6
  } cfg_reg_t;

  // Field widths
  localparam int BOUND_W = 21;
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 12;
  localparam int COLOR_W = 32;

  // Signed pixel coordinate wide enough for rounded bounds and frame sizes
  localparam int COORD_W = 15;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Q.16 coverage / fill, 0 .. 1.0
  localparam int Q16_W = 17;
  typedef logic [Q16_W-1:0] q16_t;
  localparam q16_t Q16_ONE = 17'h10000;

  // Percent numerator alpha*coverage and its full-scale value 255 * 2^16
  localparam int PCT_W = 25;
  localparam logic [PCT_W-1:0] PCT_FULL = 25'd16711680;
  // Half of the full scale, for round-to-nearest
  localparam logic [32:0] PCT_HALF = 33'd8355840;

  // Rounded and clamped bound with its edge fill
  typedef struct packed {
    coord_t pos;
    q16_t   fill;
  } bound_t;

endpackage

FILE: sv/rect_fill_alpha_blend.sv
// Rectangle fill with antialiased edges and alpha blend, nine-stage pixel pipeline.
//
// One pixel enters per clock (start high, busy low) and its result leaves on
// out_color / inside_res with done high once it leaves the last stage; results
// are never held, so the receiver must take each beat when done is high.
// busy is high only while rst is asserted. After the input capture stage come
// the top edge pick and the chain of three coverage multiplies (one 17x17
// multiplier per stage), followed by the percent, blend-sum, scaling and
// divide-by-255 correction stages.
// Configuration writes take effect for pixels started on the following
// cycle or later; write them only when no pixel is in flight.
module rect_fill_alpha_blend #(
  parameter int MAX_DIM = rfab_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rfab_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rfab_pkg::COLOR_W-1:0]     cfg_wdata,
  // pixel input
  input  logic                             start,
  output logic                             busy,
  input  logic [rfab_pkg::PIX_W-1:0]       pix_x,
  input  logic [rfab_pkg::PIX_W-1:0]       pix_y,
  input  logic [rfab_pkg::COLOR_W-1:0]     dest_color,
  // result
  output logic                             done,
  output logic [rfab_pkg::COLOR_W-1:0]     out_color,
  output logic                             inside_res
);
  import rfab_pkg::*;

  // Frame size registers are 13 bits; a ceiling above their range never bites
  localparam int DIM_MAX_REG = (1 << DIM_W) - 1;
  localparam int DIM_CAP     = (MAX_DIM > DIM_MAX_REG) ? DIM_MAX_REG : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_CAP);

  // Configuration registers
  logic [BOUND_W-1:0] start_x_q8, start_y_q8, end_x_q8, end_y_q8;
  logic [DIM_W-1:0]   frame_width, frame_height;
  logic [COLOR_W-1:0] fill_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x_q8   <= '0;
      start_y_q8   <= '0;
      end_x_q8     <= '0;
      end_y_q8     <= '0;
      frame_width  <= DIM_W'(4096);
      frame_height <= DIM_W'(4096);
      fill_color   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_START_X:  start_x_q8   <= cfg_wdata[BOUND_W-1:0];
        REG_START_Y:  start_y_q8   <= cfg_wdata[BOUND_W-1:0];
        REG_END_X:    end_x_q8     <= cfg_wdata[BOUND_W-1:0];
        REG_END_Y:    end_y_q8     <= cfg_wdata[BOUND_W-1:0];
        REG_FRAME_W:  frame_width  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_H:  frame_height <= cfg_wdata[DIM_W-1:0];
        REG_FILL_CLR: fill_color   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Round a Q.8 bound to nearest; fill is the absolute rounding error in Q.16
  function automatic bound_t round_q8(input logic [BOUND_W-1:0] raw);
    logic signed [BOUND_W:0] t;
    logic [7:0]              r;
    logic [7:0]              e;
    bound_t                  b;
    t      = $signed({raw[BOUND_W-1], raw}) + (BOUND_W+1)'(128);
    r      = t[7:0];
    e      = r[7] ? (r - 8'd128) : (8'd128 - r);
    b.pos  = {t[BOUND_W], t[BOUND_W:8]};
    b.fill = {1'b0, e, 8'h00};
    return b;
  endfunction

  // Derived bounds, recomputed from the registers every cycle
  bound_t bx0_c, by0_c, bx1_c, by1_c;
  bound_t bx0, by0, bx1, by1;
  coord_t x1m1, y1m1;
  logic [DIM_W-1:0] fw, fh;

  always_comb begin
    fw    = (frame_width  > DIM_LIM) ? DIM_LIM : frame_width;
    fh    = (frame_height > DIM_LIM) ? DIM_LIM : frame_height;
    bx0_c = round_q8(start_x_q8);
    by0_c = round_q8(start_y_q8);
    bx1_c = round_q8(end_x_q8);
    by1_c = round_q8(end_y_q8);
    if (bx0_c.pos <= 0) begin
      bx0_c.pos  = '0;
      bx0_c.fill = Q16_ONE;
    end
    if (by0_c.pos <= 0) begin
      by0_c.pos  = '0;
      by0_c.fill = Q16_ONE;
    end
    if (bx1_c.pos >= $signed({2'b00, fw})) begin
      bx1_c.pos  = $signed({2'b00, fw});
      bx1_c.fill = Q16_ONE;
    end
    if (by1_c.pos >= $signed({2'b00, fh})) begin
      by1_c.pos  = $signed({2'b00, fh});
      by1_c.fill = Q16_ONE;
    end
  end

  always_ff @(posedge clk) begin
    bx0  <= bx0_c;
    by0  <= by0_c;
    bx1  <= bx1_c;
    by1  <= by1_c;
    x1m1 <= bx1_c.pos - COORD_W'(1);
    y1m1 <= by1_c.pos - COORD_W'(1);
  end

  assign busy = rst;

  // Pipeline valid bits, stages 1..8
  logic [7:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[6:0], start & ~busy};
  end

  // Stage 1: capture the pixel beat
  logic [PIX_W-1:0]   s1_x, s1_y;
  logic [COLOR_W-1:0] s1_dest;
  always_ff @(posedge clk) begin
    s1_x    <= pix_x;
    s1_y    <= pix_y;
    s1_dest <= dest_color;
  end

  // Stage 2: inside test and edge hits; first coverage term from the top edge
  coord_t px, py;
  logic   s1_in;
  assign px    = $signed({{(COORD_W-PIX_W){1'b0}}, s1_x});
  assign py    = $signed({{(COORD_W-PIX_W){1'b0}}, s1_y});
  assign s1_in = (px >= bx0.pos) && (px < bx1.pos) && (py >= by0.pos) && (py < by1.pos);

  logic               s2_in, s2_left, s2_bot, s2_right;
  q16_t               s2_cov;
  logic [COLOR_W-1:0] s2_dest;
  always_ff @(posedge clk) begin
    s2_in    <= s1_in;
    s2_left  <= (px == bx0.pos);
    s2_bot   <= (py == y1m1);
    s2_right <= (px == x1m1);
    s2_cov   <= (py == by0.pos) ? by0.fill : Q16_ONE;
    s2_dest  <= s1_dest;
  end

  // Stages 3..5: one truncating Q.16 multiply per stage (left, bottom, right)
  logic [2*Q16_W-1:0] m3, m4, m5;
  assign m3 = s2_cov * bx0.fill;

  logic               s3_in, s3_bot, s3_right;
  q16_t               s3_cov;
  logic [COLOR_W-1:0] s3_dest;
  always_ff @(posedge clk) begin
    s3_in    <= s2_in;
    s3_bot   <= s2_bot;
    s3_right <= s2_right;
    s3_cov   <= s2_left ? m3[16 +: Q16_W] : s2_cov;
    s3_dest  <= s2_dest;
  end

  assign m4 = s3_cov * by1.fill;

  logic               s4_in, s4_right;
  q16_t               s4_cov;
  logic [COLOR_W-1:0] s4_dest;
  always_ff @(posedge clk) begin
    s4_in    <= s3_in;
    s4_right <= s3_right;
    s4_cov   <= s3_bot ? m4[16 +: Q16_W] : s3_cov;
    s4_dest  <= s3_dest;
  end

  assign m5 = s4_cov * bx1.fill;

  logic               s5_in;
  q16_t               s5_cov;
  logic [COLOR_W-1:0] s5_dest;
  always_ff @(posedge clk) begin
    s5_in   <= s4_in;
    s5_cov  <= s4_right ? m5[16 +: Q16_W] : s4_cov;
    s5_dest <= s4_dest;
  end

  // Stage 6: percent numerator alpha * coverage
  logic [PCT_W-1:0]   s6_p;
  logic               s6_in;
  logic [COLOR_W-1:0] s6_dest;
  always_ff @(posedge clk) begin
    s6_p    <= PCT_W'(fill_color[31:24] * s5_cov);
    s6_in   <= s5_in;
    s6_dest <= s5_dest;
  end

  // Stage 7: per channel d*(full-p) + s*p
  logic [PCT_W-1:0]   inv_p;
  logic [2:0][31:0]   num_c;
  assign inv_p = PCT_FULL - s6_p;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num_c[ch] = 32'(s6_dest[8*ch +: 8] * inv_p) + 32'(fill_color[8*ch +: 8] * s6_p);
    end
  end

  logic [2:0][31:0]   s7_num;
  logic               s7_in, s7_full;
  logic [COLOR_W-1:0] s7_dest;
  always_ff @(posedge clk) begin
    s7_num  <= num_c;
    s7_in   <= s6_in;
    s7_full <= (s6_p == PCT_FULL);
    s7_dest <= s6_dest;
  end

  // Stage 8: round and scale by 2^16, first estimate of the divide by 255
  logic [2:0][32:0] rsum;
  logic [2:0][15:0] q_c;
  logic [2:0][24:0] q257;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rsum[ch] = {1'b0, s7_num[ch]} + PCT_HALF;
      q_c[ch]  = rsum[ch][31:16];
      q257[ch] = {1'b0, q_c[ch], 8'h00} + {9'h000, q_c[ch]};
    end
  end

  logic [2:0][15:0]   s8_q;
  logic [2:0][7:0]    s8_c0;
  logic               s8_in, s8_full;
  logic [COLOR_W-1:0] s8_dest;
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      s8_q[ch]  <= q_c[ch];
      s8_c0[ch] <= q257[ch][23:16];
    end
    s8_in   <= s7_in;
    s8_full <= s7_full;
    s8_dest <= s7_dest;
  end

  // Stage 9: correct the quotient by one where the remainder reaches 255
  logic [2:0][16:0] rem;
  logic [2:0][7:0]  chan;
  logic [COLOR_W-1:0] blend;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rem[ch]  = {1'b0, s8_q[ch]} - ({1'b0, s8_c0[ch], 8'h00} - {9'h000, s8_c0[ch]});
      chan[ch] = (rem[ch] >= 17'd255) ? (s8_c0[ch] + 8'd1) : s8_c0[ch];
    end
    blend = {fill_color[31:24], chan[2], chan[1], chan[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[7];
    end
    inside_res <= s8_in;
    if (!s8_in)       out_color <= s8_dest;
    else if (s8_full) out_color <= fill_color;
    else              out_color <= blend;
  end

endmodule

FILE: sim/rect_fill_alpha_blend_tb.sv
// Self-checking testbench for the rectangle fill and alpha blend pipeline.
module rect_fill_alpha_blend_tb;
  import rfab_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP = 40;
  localparam longint unsigned FULL_PCT = 64'd16711680;   // 255 * 2^16
  localparam longint unsigned COV_ONE = 64'd65536;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // no register at this index

  // Expected pixel result
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               in_rect;
  } blend_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COLOR_W-1:0]   cfg_wdata;
  logic                 start;
  logic                 busy;
  logic [PIX_W-1:0]     pix_x;
  logic [PIX_W-1:0]     pix_y;
  logic [COLOR_W-1:0]   dest_color;
  logic                 done;
  logic [COLOR_W-1:0]   out_color;
  logic                 inside_res;

  // Shadow copy of the register file
  logic [BOUND_W-1:0] rect_x0_q8, rect_y0_q8, rect_x1_q8, rect_y1_q8;
  logic [DIM_W-1:0]   frame_w, frame_h;
  logic [COLOR_W-1:0] src_color;

  blend_t blend_q[$];
  blend_t pending_px;
  blend_t got_px;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_inside = 0;
  int n_configs = 0;
  int idle_cycles = 0;

  rect_fill_alpha_blend dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .dest_color (dest_color),
    .done       (done),
    .out_color  (out_color),
    .inside_res (inside_res)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Round a Q.8 bound to nearest; fill gets the rounding error in Q.16
  function automatic longint edge_round(input logic [BOUND_W-1:0] raw,
                                        output longint unsigned fill);
    longint v, m, e;
    v = longint'($signed(raw));
    m = (v + 128) >>> 8;
    e = v - m * 256;
    if (e < 0) e = -e;
    fill = longint'(e) << 8;
    return m;
  endfunction

  function automatic longint frame_limit(input logic [DIM_W-1:0] r);
    return (r > MAX_DIM_DEF) ? longint'(MAX_DIM_DEF) : longint'(r);
  endfunction

  // Expected result of one pixel under the shadow configuration
  function automatic blend_t blend_pixel(input logic [PIX_W-1:0] px, py,
                                         input logic [COLOR_W-1:0] dst);
    longint unsigned fx0, fy0, fx1, fy1, cov, alpha, pct, num, c, s, d;
    longint x0, y0, x1, y1, fw, fh, xi, yi;
    blend_t r;
    xi = longint'(px);
    yi = longint'(py);
    x0 = edge_round(rect_x0_q8, fx0);
    y0 = edge_round(rect_y0_q8, fy0);
    x1 = edge_round(rect_x1_q8, fx1);
    y1 = edge_round(rect_y1_q8, fy1);
    fw = frame_limit(frame_w);
    fh = frame_limit(frame_h);
    // clamped edges are fully covered
    if (x0 <= 0) begin x0 = 0; fx0 = COV_ONE; end
    if (y0 <= 0) begin y0 = 0; fy0 = COV_ONE; end
    if (x1 >= fw) begin x1 = fw; fx1 = COV_ONE; end
    if (y1 >= fh) begin y1 = fh; fy1 = COV_ONE; end
    if (xi < x0 || xi >= x1 || yi < y0 || yi >= y1) begin
      r.color = dst;
      r.in_rect = 1'b0;
      return r;
    end
    // edge coverage, top, left, bottom, right, truncating each time
    cov = COV_ONE;
    if (yi == y0) cov = (cov * fy0) >> 16;
    if (xi == x0) cov = (cov * fx0) >> 16;
    if (yi == y1 - 1) cov = (cov * fy1) >> 16;
    if (xi == x1 - 1) cov = (cov * fx1) >> 16;
    alpha = longint'(src_color[31:24]);
    pct = alpha * cov;
    r.in_rect = 1'b1;
    if (pct == FULL_PCT) begin
      r.color = src_color;
    end else begin
      r.color = {src_color[31:24], 24'h0};
      for (int sh = 0; sh < 24; sh += 8) begin
        s = longint'(src_color[sh +: 8]);
        d = longint'(dst[sh +: 8]);
        num = d * (FULL_PCT - pct) + s * pct;
        c = (2 * num + FULL_PCT) / (2 * FULL_PCT);
        r.color[sh +: 8] = c[7:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Accept beats, check results, watch for a hang
  always @(posedge clk) begin
    if (start && !busy) begin
      pending_px = blend_pixel(pix_x, pix_y, dest_color);
      blend_q.push_back(pending_px);
      n_sent++;
    end
    if (done === 1'b1) begin
      if (blend_q.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with no pixel outstanding",
                                  out_color, inside_res));
      end else begin
        got_px = blend_q.pop_front();
        if (out_color !== got_px.color)
          report_mismatch($sformatf("out_color %h, want %h (result %0d)",
                                    out_color, got_px.color, n_checked));
        if (inside_res !== got_px.in_rect)
          report_mismatch($sformatf("inside_res %b, want %b (result %0d)",
                                    inside_res, got_px.in_rect, n_checked));
        n_checked++;
        if (got_px.in_rect) n_inside++;
      end
    end
    if ((start && !busy) || done === 1'b1) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a beat", idle_cycles);
      $display("rect_fill_alpha_blend_tb: FAIL");
      $finish;
    end
  end

  // One pixel beat; returns on the falling edge after acceptance
  task automatic send_pixel(input logic [PIX_W-1:0] px, py,
                            input logic [COLOR_W-1:0] dst);
    start <= 1'b1;
    pix_x <= px;
    pix_y <= py;
    dest_color <= dst;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random sender gap with start low, taken with a chance of pct percent
  task automatic maybe_idle(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic write_beat(input logic [CFG_IDX_W-1:0] idx,
                            input logic [COLOR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Drain the pipeline, then rewrite every register (upper junk bits set)
  task automatic program_rect(input int sx, sy, ex, ey, fw, fh,
                              input logic [COLOR_W-1:0] color);
    logic [31:0] junk;
    start <= 1'b0;
    while (blend_q.size() != 0) @(negedge clk);
    junk = $urandom;
    rect_x0_q8 = sx[BOUND_W-1:0];
    rect_y0_q8 = sy[BOUND_W-1:0];
    rect_x1_q8 = ex[BOUND_W-1:0];
    rect_y1_q8 = ey[BOUND_W-1:0];
    frame_w = fw[DIM_W-1:0];
    frame_h = fh[DIM_W-1:0];
    src_color = color;
    write_beat(REG_UNUSED, $urandom);
    write_beat(REG_START_X, {junk[31:BOUND_W], rect_x0_q8});
    write_beat(REG_START_Y, {junk[BOUND_W-1:10], rect_y0_q8});
    write_beat(REG_END_X, {~junk[31:BOUND_W], rect_x1_q8});
    write_beat(REG_END_Y, {junk[20:10], rect_y1_q8});
    write_beat(REG_FRAME_W, {junk[31:DIM_W], frame_w});
    write_beat(REG_FRAME_H, {~junk[31:DIM_W], frame_h});
    write_beat(REG_FILL_CLR, src_color);
    cfg_we <= 1'b0;
    n_configs++;
  endtask

  // Reset state: all bounds zero, so nothing is inside
  task automatic test_reset_state();
    send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
    send_pixel(12'hFFF, 12'hFFF, 32'h0000_0000);
  endtask

  // Fractional edges, opaque source: corner, interior, edges, outside
  task automatic test_edge_fills();
    // left 0.5 (exact half), top 10.25, right 20.78, bottom exactly 30
    program_rect(32'h80, 10 * 256 + 64, 20 * 256 + 200, 30 * 256, 4096, 4096,
                 32'hFF33_6699);
    send_pixel(12'd1, 12'd10, 32'hFFFF_FFFF);
    send_pixel(12'd10, 12'd15, 32'h0000_0000);
    send_pixel(12'd20, 12'd15, 32'h1234_5678);
    send_pixel(12'd10, 12'd29, 32'hA5A5_A5A5);
    send_pixel(12'd0, 12'd15, 32'hDEAD_BEEF);
    send_pixel(12'd21, 12'd15, 32'hDEAD_BEEF);
    send_pixel(12'd10, 12'd30, 32'hDEAD_BEEF);
  endtask

  // One-pixel rectangle: both fills of each axis apply
  task automatic test_single_pixel_rect();
    program_rect(5 * 256 + 64, 7 * 256 + 64, 5 * 256 + 192, 7 * 256 + 192,
                 4096, 4096, 32'h80FF_0080);
    send_pixel(12'd5, 12'd7, 32'h0000_FF00);
    send_pixel(12'd6, 12'd7, 32'h0000_FF00);
    send_pixel(12'd5, 12'd6, 32'hFFFF_FFFF);
  endtask

  // Extreme bounds, empty frame, oversized frame, 1x1 frame, alpha 0
  task automatic test_clamping();
    program_rect(-1048576, -1048576, 1048575, 1048575, 0, 4096, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0, 32'h0102_0304);
    send_pixel(12'd100, 12'd100, 32'h0102_0304);
    program_rect(-1048576, -1048576, 1048575, 1048575, 8191, 4096, 32'h00FF_FFFF);
    send_pixel(12'd0, 12'd0, 32'h8040_2010);
    send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    program_rect(-128, -129, 1048575, 127, 1, 1, 32'hC0FF_8000);
    send_pixel(12'd0, 12'd0, 32'h0000_00FF);
    send_pixel(12'd1, 12'd0, 32'h0000_00FF);
  endtask

  function automatic int pick_frame();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 0;
    if (k == 1) return $urandom_range(MAX_DIM_DEF + 1, 8191);
    if (k == 2) return MAX_DIM_DEF;
    if (k <= 5) return $urandom_range(1, MAX_DIM_DEF);
    return $urandom_range(1, 48);
  endfunction

  // Start bound around the frame, Q.8, sometimes forced to an exact or half position
  function automatic int pick_start(input int span);
    int v;
    v = int'($urandom_range(0, (span + 2) * 256)) - 3 * 256;
    case ($urandom_range(0, 5))
      0: v = (v & ~255) | 128;
      1: v = v & ~255;
      default: ;
    endcase
    return v;
  endfunction

  function automatic int pick_end(input int sx, span);
    int v;
    if ($urandom_range(0, 4) == 0) v = pick_start(span);
    else v = sx + int'($urandom_range(0, 12 * 256));
    if ($urandom_range(0, 5) == 0) v = (v & ~255) | 128;
    return (v > 1048575) ? 1048575 : v;
  endfunction

  function automatic logic [PIX_W-1:0] pick_coord(input int lo_q8, hi_q8);
    int lo, hi;
    lo = (lo_q8 >>> 8) - 2;
    hi = (hi_q8 >>> 8) + 2;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    if (lo > hi || $urandom_range(0, 4) == 0) return PIX_W'($urandom);
    return PIX_W'($urandom_range(lo, hi));
  endfunction

  // Random rectangles and colors, pixels mostly near the edges
  task automatic test_random_fills(input int idle_pct, segments, per_segment);
    int fw, fh, sx, sy, ex, ey, span_x, span_y, k;
    logic [COLOR_W-1:0] color, dst;
    for (int seg = 0; seg < segments; seg++) begin
      fw = pick_frame();
      fh = pick_frame();
      span_x = (fw > MAX_DIM_DEF || fw == 0) ? MAX_DIM_DEF : fw;
      span_y = (fh > MAX_DIM_DEF || fh == 0) ? MAX_DIM_DEF : fh;
      sx = pick_start(span_x);
      sy = pick_start(span_y);
      ex = pick_end(sx, span_x);
      ey = pick_end(sy, span_y);
      if ($urandom_range(0, 9) == 0) begin
        sx = $urandom;
        ex = $urandom;
        sx = sx >>> 11;
        ex = ex >>> 11;
      end
      color = $urandom;
      k = $urandom_range(0, 9);
      if (k < 3) color[31:24] = 8'hFF;
      else if (k == 3) color[31:24] = 8'h00;
      program_rect(sx, sy, ex, ey, fw, fh, color);
      for (int i = 0; i < per_segment; i++) begin
        maybe_idle(idle_pct);
        dst = $urandom;
        k = $urandom_range(0, 19);
        if (k == 0) dst = 32'h0000_0000;
        else if (k == 1) dst = 32'hFFFF_FFFF;
        send_pixel(pick_coord(sx, ex), pick_coord(sy, ey), dst);
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= REG_START_X;
    cfg_wdata <= '0;
    start <= 1'b0;
    pix_x <= '0;
    pix_y <= '0;
    dest_color <= '0;
    rect_x0_q8 = '0;
    rect_y0_q8 = '0;
    rect_x1_q8 = '0;
    rect_y1_q8 = '0;
    frame_w = DIM_W'(MAX_DIM_DEF);
    frame_h = DIM_W'(MAX_DIM_DEF);
    src_color = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_edge_fills();
    test_single_pixel_rect();
    test_clamping();
    test_random_fills(24, 6, 30);
    test_random_fills(58, 6, 30);
    test_random_fills(0, 6, 30);

    start <= 1'b0;
    while (blend_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d pixels over %0d rectangle setups, %0d results checked",
             n_sent, n_configs, n_checked);
    $display("%0d pixels blended inside, %0d passed through, %0d mismatches",
             n_inside, n_checked - n_inside, errors);
    if (errors == 0 && blend_q.size() == 0) begin
      $display("rect_fill_alpha_blend_tb: PASS");
    end else begin
      $display("rect_fill_alpha_blend_tb: FAIL");
    end
    $finish;
  end

endmodule
